### rtl/musbf_pkg.sv
// Package for the maximum uniform subsidy search block.
// Holds sizes, distance type and controller command/status structs; no dependencies.
`timescale 1ns / 1ps
package musbf_pkg;
    localparam int MAX_NODES = 64;
    localparam int MAX_EDGES = 1024;
    localparam int COST_BITS = 16;
    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int EDGE_W = $clog2(MAX_EDGES);
    localparam int CNT_W = EDGE_W + 1;
    localparam int DIST_W = 32;
    localparam int K_W = COST_BITS + 1;

    typedef logic [NODE_W-1:0] node_t;
    typedef logic signed [DIST_W-1:0] dist_t;

    // Controller to datapath.
    typedef struct packed {
        logic init_search;   // load low/high bounds
        logic init_probe;    // clear valid bits, set source, compute k
        logic clear_flags;   // clear the changed flag before a round
        logic rd_edge;       // issue a read of the stored edge at the cursor
        logic rd_virt;       // issue a virtual edge at the cursor
        logic step_cursor;
        logic reset_cursor;
        logic decide;        // update bounds from the probe outcome
        logic finish;        // clear graph state after the result
    } musbf_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic search_done;
        logic edges_done;
        logic virt_done;
    } musbf_sts_t;
endpackage

### rtl/musbf_datapath.sv
// Datapath: edge memories, distance memory, search bounds and relaxation unit.
// Depends on musbf_pkg; driven by musbf_ctrl through musbf_cmd_t.
`timescale 1ns / 1ps
module musbf_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               load_en,
    input  logic [musbf_pkg::NODE_W-1:0]       load_from,
    input  logic [musbf_pkg::NODE_W-1:0]       load_to,
    input  logic signed [musbf_pkg::COST_BITS-1:0] load_cost,
    input  logic [musbf_pkg::NODE_W-1:0]       node_count,
    input  musbf_pkg::musbf_cmd_t              cmd,
    output musbf_pkg::musbf_sts_t              sts,
    output logic [14:0]                        subsidy,
    output logic                               dropped
);
    import musbf_pkg::*;

    localparam dist_t DMAX = {1'b0, {(DIST_W-1){1'b1}}};
    localparam dist_t DMIN = {1'b1, {(DIST_W-1){1'b0}}};

    logic [NODE_W-1:0] from_mem [MAX_EDGES];
    logic [NODE_W-1:0] to_mem [MAX_EDGES];
    logic signed [COST_BITS-1:0] cost_mem [MAX_EDGES];
    dist_t dist_mem [MAX_NODES];

    logic [CNT_W-1:0] total_reg, total_next;
    logic signed [COST_BITS-1:0] max_reg, max_next;
    logic dropped_reg, dropped_next;
    logic signed [K_W:0] low_reg, high_reg, k_reg;
    logic [CNT_W-1:0] cur_reg;
    logic [MAX_NODES-1:0] valid_reg;
    logic changed_reg, floor_reg;
    logic [NODE_W-1:0] n_eff;

    // Issue stage (registered memory reads).
    logic iss_reg;
    logic [NODE_W-1:0] a_reg, b_reg;
    logic signed [K_W:0] w_reg;
    logic skip_reg;
    dist_t da_reg, db_reg;
    logic [NODE_W-1:0] e_from, e_to;
    logic signed [COST_BITS-1:0] e_cost;
    logic e_pend;

    assign n_eff = node_count;

    always_comb
    begin
        total_next = total_reg;
        max_next = max_reg;
        dropped_next = dropped_reg;
        if (load_en)
        begin
            if (total_reg < CNT_W'(MAX_EDGES))
                total_next = total_reg + 1'b1;
            else
                dropped_next = 1'b1;
            if (load_cost > max_reg)
                max_next = load_cost;
        end
        if (cmd.finish)
        begin
            total_next = '0;
            max_next = '0;
            dropped_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en && total_reg < CNT_W'(MAX_EDGES))
        begin
            from_mem[total_reg[EDGE_W-1:0]] <= load_from;
            to_mem[total_reg[EDGE_W-1:0]] <= load_to;
            cost_mem[total_reg[EDGE_W-1:0]] <= load_cost;
        end
        e_from <= from_mem[cur_reg[EDGE_W-1:0]];
        e_to <= to_mem[cur_reg[EDGE_W-1:0]];
        e_cost <= cost_mem[cur_reg[EDGE_W-1:0]];
    end

    // Edge read: the memory word is ready in the cycle after rd_edge, the
    // distances are read in that cycle, and the relaxation follows in the next cycle.
    logic virt_pend;
    logic [NODE_W-1:0] v_idx;
    logic [NODE_W-1:0] s1_a, s1_b;
    logic signed [K_W:0] s1_w;
    logic s1_skip;

    always_comb
    begin
        s1_a = e_from;
        s1_b = e_to;
        s1_w = (K_W+1)'(e_cost) - k_reg;
        s1_skip = (e_from >= n_eff) || (e_to >= n_eff);
        if (virt_pend)
        begin
            s1_a = n_eff;
            s1_b = v_idx;
            s1_w = (K_W+1)'(1) - k_reg;
            s1_skip = 1'b0;
        end
    end

    logic signed [DIST_W+1:0] sum;
    dist_t c_sat;
    logic a_ok, b_ok, b_fwd;
    dist_t db_use;

    // Forward a write to the same node from the previous relaxation.
    logic wr_reg;
    logic [NODE_W-1:0] wr_node_reg;
    dist_t wr_val_reg;

    always_comb
    begin
        dist_t da_use;
        da_use = (wr_reg && wr_node_reg == a_reg) ? wr_val_reg : da_reg;
        b_fwd = wr_reg && wr_node_reg == b_reg;
        db_use = b_fwd ? wr_val_reg : db_reg;
        a_ok = valid_reg[a_reg];
        b_ok = valid_reg[b_reg];
        sum = (DIST_W+2)'(da_use) + (DIST_W+2)'(w_reg);
        if (sum > (DIST_W+2)'(DMAX))
            c_sat = DMAX;
        else if (sum < (DIST_W+2)'(DMIN))
            c_sat = DMIN;
        else
            c_sat = sum[DIST_W-1:0];
    end

    logic do_wr;
    assign do_wr = iss_reg && !skip_reg && a_ok && (!b_ok || c_sat < db_use);

    always_ff @(posedge clk)
    begin
        if (e_pend || virt_pend)
        begin
            da_reg <= dist_mem[s1_a];
            db_reg <= dist_mem[s1_b];
        end
        if (cmd.init_probe)
            dist_mem[n_eff] <= '0;
        else if (do_wr)
            dist_mem[b_reg] <= c_sat;
        a_reg <= s1_a;
        b_reg <= s1_b;
        w_reg <= s1_w;
        skip_reg <= s1_skip;
        wr_node_reg <= b_reg;
        wr_val_reg <= c_sat;
        v_idx <= cur_reg[NODE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            max_reg <= '0;
            dropped_reg <= 1'b0;
            low_reg <= '0;
            high_reg <= '0;
            k_reg <= '0;
            cur_reg <= '0;
            valid_reg <= '0;
            changed_reg <= 1'b0;
            floor_reg <= 1'b0;
            e_pend <= 1'b0;
            virt_pend <= 1'b0;
            iss_reg <= 1'b0;
            wr_reg <= 1'b0;
        end
        else
        begin
            total_reg <= total_next;
            max_reg <= max_next;
            dropped_reg <= dropped_next;
            e_pend <= cmd.rd_edge;
            virt_pend <= cmd.rd_virt;
            iss_reg <= e_pend || virt_pend;
            wr_reg <= do_wr;
            if (cmd.init_search)
            begin
                low_reg <= '0;
                // The closing word's cost counts toward the upper bound.
                high_reg <= (K_W+1)'(max_next) + 1'b1;
            end
            if (cmd.init_probe)
            begin
                k_reg <= low_reg + ((high_reg - low_reg) >>> 1);
                valid_reg <= {{(MAX_NODES-1){1'b0}}, 1'b1} << n_eff;
                floor_reg <= 1'b0;
            end
            if (cmd.clear_flags)
                changed_reg <= 1'b0;
            if (do_wr)
            begin
                valid_reg[b_reg] <= 1'b1;
                changed_reg <= 1'b1;
                if (c_sat == DMIN)
                    floor_reg <= 1'b1;
            end
            if (cmd.reset_cursor)
                cur_reg <= '0;
            else if (cmd.step_cursor)
                cur_reg <= cur_reg + 1'b1;
            if (cmd.decide)
            begin
                if (changed_reg || floor_reg)
                    high_reg <= k_reg;
                else
                    low_reg <= k_reg;
            end
        end
    end

    assign sts.search_done = !(low_reg + 1 < high_reg);
    assign sts.edges_done = cur_reg >= total_reg;
    assign sts.virt_done = cur_reg >= CNT_W'(n_eff);
    assign subsidy = low_reg[14:0];
    assign dropped = dropped_reg;

    a_src: assert property (@(posedge clk) disable iff (!rst_n)
        iss_reg |-> valid_reg[n_eff])
        else $error("source node lost its distance");
    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide |=> low_reg < high_reg || low_reg == high_reg)
        else $error("search bounds crossed");
    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> total_reg == '0 && !dropped_reg)
        else $error("graph state not cleared");
    a_k: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.init_probe) |-> k_reg > low_reg && k_reg < high_reg)
        else $error("probe outside search window");
endmodule

### rtl/musbf_ctrl.sv
// Controller: sequences loading, probes, relaxation rounds and the result.
// Depends on musbf_pkg; commands musbf_datapath.
`timescale 1ns / 1ps
module musbf_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [musbf_pkg::NODE_W-1:0] node_count,
    input  musbf_pkg::musbf_sts_t sts,
    input  logic                  out_taken,
    output musbf_pkg::musbf_cmd_t cmd,
    output logic                  idle,
    output logic                  result_valid
);
    import musbf_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0, S_SEARCH = 3'd1, S_EDGE = 3'd2,
                           S_VIRT = 3'd3, S_DRAIN = 3'd4, S_ROUND = 3'd5,
                           S_DONE = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [NODE_W:0] round_reg, round_next;
    logic [1:0] drain_reg, drain_next;

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        drain_next = drain_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.init_search = 1'b1;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (sts.search_done)
                    state_next = S_DONE;
                else
                begin
                    cmd.init_probe = 1'b1;
                    cmd.reset_cursor = 1'b1;
                    cmd.clear_flags = 1'b1;
                    round_next = '0;
                    state_next = S_EDGE;
                end
            end
            S_EDGE:
            begin
                if (sts.edges_done)
                begin
                    cmd.reset_cursor = 1'b1;
                    state_next = S_VIRT;
                end
                else
                begin
                    cmd.rd_edge = 1'b1;
                    cmd.step_cursor = 1'b1;
                    // Edges are sequential through the pipeline; wait out
                    // each so no read sees a stale distance.
                    state_next = S_DRAIN;
                    drain_next = 2'd3;
                end
            end
            S_DRAIN:
            begin
                drain_next = drain_reg - 1'b1;
                if (drain_reg == 2'd1)
                    state_next = sts.edges_done ? S_EDGE : S_EDGE;
            end
            S_VIRT:
            begin
                if (sts.virt_done)
                    state_next = S_ROUND;
                else
                begin
                    cmd.rd_virt = 1'b1;
                    cmd.step_cursor = 1'b1;
                    state_next = S_DRAIN;
                    drain_next = 2'd3;
                end
            end
            S_ROUND:
            begin
                cmd.reset_cursor = 1'b1;
                if (round_reg == {1'b0, node_count} + 1'b1)
                begin
                    cmd.decide = 1'b1;
                    state_next = S_SEARCH;
                end
                else
                begin
                    round_next = round_reg + 1'b1;
                    cmd.clear_flags = 1'b1;
                    state_next = S_EDGE;
                end
            end
            S_DONE:
            begin
                if (out_taken)
                begin
                    cmd.finish = 1'b1;
                    round_next = '0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // After a virtual edge drains, return to the virtual phase.
    logic in_virt_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            round_reg <= '0;
            drain_reg <= '0;
            in_virt_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_DRAIN && drain_reg == 2'd1 && in_virt_reg)
                state_reg <= S_VIRT;
            else
                state_reg <= state_next;
            round_reg <= round_next;
            drain_reg <= drain_next;
            if (state_reg == S_VIRT)
                in_virt_reg <= 1'b1;
            else if (state_reg == S_EDGE || state_reg == S_ROUND)
                in_virt_reg <= 1'b0;
        end
    end

    assign idle = state_reg == S_IDLE;
    assign result_valid = state_reg == S_DONE;

    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.rd_edge, cmd.rd_virt, cmd.decide}))
        else $error("conflicting commands");
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> idle)
        else $error("finish did not return to idle");
    a_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        round_reg <= {1'b0, node_count} + 2'd2)
        else $error("round counter overran");
endmodule

### rtl/max_uniform_subsidy_bellman_ford.sv
// Top level of the maximum uniform subsidy search block.
// Depends on musbf_pkg, musbf_ctrl and musbf_datapath.
//
// Usage: edges arrive on the input channel (valid/ready), one word per cycle
// while the block is idle. A word with last_edge set closes the graph and
// starts a binary search over k in [0, max_cost+1); ready stays low until the
// search has ended and its result has moved into the output register.
// Each of the P probes (P <= ceil(log2(max_cost+1))) runs node_count+2
// Bellman-Ford rounds; a round visits every stored edge and then every virtual
// source edge, one at a time, and waits for each to drain from the pipeline
// before it issues the next one.
// The result word (subsidy, edge_overflow) waits in the output register, so
// the next graph can load meanwhile; if the receiver still stalls when the
// next search ends, the block waits in its done state with ready low.
// node_count is written on the cfg channel, which is ready only while idle.
// Reset clears all control state; node_count returns to 1. Edge memories need
// no clearing pass since they are always written before being read.
`timescale 1ns / 1ps
module max_uniform_subsidy_bellman_ford (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [5:0]  edge_from,
    input  logic [5:0]  edge_to,
    input  logic signed [15:0] edge_cost,
    input  logic        last_edge,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [14:0] subsidy,
    output logic        edge_overflow
);
    import musbf_pkg::*;

    logic [NODE_W-1:0] node_count_reg;
    musbf_cmd_t cmd;
    musbf_sts_t sts;
    logic idle, load_en;
    logic search_done, out_space;
    logic [14:0] dp_subsidy;
    logic dp_dropped;
    logic out_valid_reg;
    logic [14:0] subsidy_reg;
    logic overflow_reg;

    assign cfg_ready = idle;
    assign in_ready = idle;
    assign load_en = in_valid && in_ready;
    assign out_space = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            node_count_reg <= NODE_W'(1);
        else if (cfg_valid && cfg_ready)
            node_count_reg <= cfg_data;
    end

    // The finished search hands its word over whenever the register has room.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            subsidy_reg <= '0;
            overflow_reg <= 1'b0;
        end
        else if (search_done && out_space)
        begin
            out_valid_reg <= 1'b1;
            subsidy_reg <= dp_subsidy;
            overflow_reg <= dp_dropped;
        end
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;
    assign subsidy = subsidy_reg;
    assign edge_overflow = overflow_reg;

    musbf_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(load_en && last_edge),
        .node_count(node_count_reg), .sts(sts), .out_taken(out_space),
        .cmd(cmd), .idle(idle), .result_valid(search_done)
    );

    musbf_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .load_en(load_en), .load_from(edge_from),
        .load_to(edge_to), .load_cost(edge_cost), .node_count(node_count_reg),
        .cmd(cmd), .sts(sts), .subsidy(dp_subsidy), .dropped(dp_dropped)
    );
endmodule
